// ----- sv/vftf_pkg.sv -----
// package for the video frame timestamp fixer
// holds widths, codes, record types and a saturation helper; no dependencies
`default_nettype none
package vftf_pkg;

   localparam int TS_W               = 48;
   localparam int TAG_W              = 32;
   localparam int DIFF_W             = TS_W + 1;
   localparam int REQ_TDATA_W        = 216;
   localparam int RSP_TDATA_W        = 216;
   localparam int MAX_RESULTS        = 32;
   localparam int HISTORY_DEF        = 5;
   localparam int MAX_DISCARD_DEF    = 16;
   localparam int CONFIG_DEPTH_DEF   = 4;
   localparam logic [31:0] DEFAULT_DURATION = 32'd40000;

   localparam logic [1:0] REQ_FRAME  = 2'd0;
   localparam logic [1:0] REQ_CONFIG = 2'd1;
   localparam logic [1:0] REQ_FLUSH  = 2'd2;

   localparam logic [1:0] KIND_FRAME    = 2'd0;
   localparam logic [1:0] KIND_ANNOUNCE = 2'd1;
   localparam logic [1:0] KIND_NO_TS    = 2'd2;
   localparam logic [1:0] KIND_CFG_FULL = 2'd3;

   localparam logic signed [TS_W-1:0] MAX_TS = {1'b0, {(TS_W-1){1'b1}}};

   typedef struct packed {
      logic [TAG_W-1:0]       tag;
      logic signed [TS_W-1:0] pts;
      logic signed [TS_W-1:0] dts;
      logic signed [TS_W-1:0] dur;
      logic                   dur_ok;
      logic                   key;
   } pend_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic [TAG_W-1:0]       frame_tag;
      logic [TAG_W-1:0]       cfg_tag;
      logic signed [TS_W-1:0] pts;
      logic signed [TS_W-1:0] dts;
      logic signed [TS_W-1:0] dur;
      logic                   key;
   } rsp_type;

   // clamp a non-negative difference to the 48 bit range
   function automatic logic signed [TS_W-1:0] sat_ts(input logic signed [DIFF_W-1:0] v);
      if (v > {MAX_TS[TS_W-1], MAX_TS}) return MAX_TS;
      return v[TS_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- sv/vftf_div.sv -----
// iterative restoring divider, one quotient bit per cycle, truncates toward zero
// depends on nothing but its parameters
`default_nettype none
module vftf_div #(
   parameter int DVD_W = 49,
   parameter int DVR_W = 5
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  wire signed [DVD_W-1:0]  dividend,
   input  wire [DVR_W-1:0]         divisor,
   output logic                    done,
   output logic signed [DVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic               busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DVD_W-1:0]   quo_ff, quo_in;
   logic [DVR_W-1:0]   rem_ff, rem_in;
   logic [DVR_W:0]     trial;
   logic               ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      ge      = trial >= {1'b0, divisor};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DVD_W-1];
         quo_in  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? DVR_W'(trial - {1'b0, divisor}) : trial[DVR_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule
`default_nettype wire

// ----- sv/vftf_pend_mem.sv -----
// pending frame memory, one write port and one registered read port
// depends on nothing but its parameters
`default_nettype none
module vftf_pend_mem #(
   parameter int DEPTH = 22,
   parameter int WIDTH = 178
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire                       rd_en,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ----- sv/vftf_rsp_stage.sv -----
// result staging: holds the newest item until the next one shows whether it is last
// depends on vftf_pkg
`default_nettype none
module vftf_rsp_stage (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 put_valid,
   input  vftf_pkg::rsp_type                   put_rec,
   output logic                                put_ready,
   input  wire                                 finish,
   output logic                                finish_done,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [vftf_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // frame_tag, out_config_tag, out_pts, out_dts, out_duration, out_key_frame
   output logic [1:0]                          rsp_tuser,  // out_kind
   output logic                                rsp_tlast
);
   logic              hold_valid_ff, hold_valid_in, out_valid_ff, out_valid_in;
   logic              out_last_ff, out_last_in;
   vftf_pkg::rsp_type hold_ff, hold_in, out_ff, out_in;
   logic              out_free;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign put_ready   = !hold_valid_ff || out_free;
   assign finish_done = !hold_valid_ff || out_free;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      if (put_valid && put_ready) begin
         if (hold_valid_ff) begin
            out_in       = hold_ff;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
         end
         hold_in       = put_rec;
         hold_valid_in = 1'b1;
      end else if (finish && hold_valid_ff && out_free) begin
         out_in        = hold_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {7'd0, out_ff.key, out_ff.dur, out_ff.dts, out_ff.pts,
                        out_ff.cfg_tag, out_ff.frame_tag};
endmodule
`default_nettype wire

// ----- sv/video_frame_timestamp_fixer_top.sv -----
// top level of the video frame timestamp fixer: sequencer, state and windows
// depends on vftf_pkg, vftf_div, vftf_pend_mem and vftf_rsp_stage
`default_nettype none
// Takes frame, config-mark and flush items and returns frames with repaired
// timestamps and durations, config announcements and error marks; req_tready
// is high only while the sequencer is idle. A key frame that follows
// discarded frames runs the shared divider twice and writes one pending
// entry per discarded frame, one per cycle. An emitted frame that has no
// duration of its own first scans the remaining pending entries through the
// one read port of the pending memory and then the history entries; any
// emitted item may also wait on rsp_tready.
module video_frame_timestamp_fixer_top #(
   parameter int HISTORY      = vftf_pkg::HISTORY_DEF,
   parameter int MAX_DISCARD  = vftf_pkg::MAX_DISCARD_DEF,
   parameter int CONFIG_DEPTH = vftf_pkg::CONFIG_DEPTH_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [vftf_pkg::REQ_TDATA_W-1:0]   req_tdata,  // frame_tag, new_config_tag, pts_valid, in_pts, in_dts, in_key_frame, duration_valid, in_duration
   input  wire [1:0]                         req_tuser,  // req_type
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [vftf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // out_frame_tag, out_config_tag, out_pts, out_dts, out_duration, out_key_frame
   output logic [1:0]                        rsp_tuser,  // out_kind
   output logic                              rsp_tlast,
   input  wire                               csr_wr_en,
   input  wire [31:0]                        csr_wr_data
);
   localparam int TS_W   = vftf_pkg::TS_W;
   localparam int DIFF_W = vftf_pkg::DIFF_W;
   localparam int PEND   = HISTORY + MAX_DISCARD + 1;
   localparam int PA_W   = $clog2(PEND);
   localparam int PC_W   = $clog2(PEND + 1);
   localparam int DR_W   = $clog2(MAX_DISCARD + 1);
   localparam int HC_W   = $clog2(HISTORY + 1);
   localparam int HI_W   = (HISTORY > 1) ? $clog2(HISTORY) : 1;
   localparam int CQ_W   = $clog2(CONFIG_DEPTH + 1);
   localparam int CI_W   = (CONFIG_DEPTH > 1) ? $clog2(CONFIG_DEPTH) : 1;
   localparam int RC_W   = $clog2(vftf_pkg::MAX_RESULTS + 1);
   localparam int PW     = $bits(vftf_pkg::pend_type);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_PUT_ERR  = 13'b0000000000010,
      ST_DIV_P    = 13'b0000000000100,
      ST_DIV_D    = 13'b0000000001000,
      ST_PUSH_I   = 13'b0000000010000,
      ST_PUSH_F   = 13'b0000000100000,
      ST_CHECK    = 13'b0000001000000,
      ST_HEAD     = 13'b0000010000000,
      ST_SCAN_RD  = 13'b0000100000000,
      ST_SCAN_CMP = 13'b0001000000000,
      ST_HIST     = 13'b0010000000000,
      ST_EMIT     = 13'b0100000000000,
      ST_FINISH   = 13'b1000000000000
   } state_type;

   // input fields
   logic [1:0]             f_type;
   logic [31:0]            f_tag, f_ctag;
   logic                   f_pts_ok, f_key, f_dur_ok;
   logic signed [TS_W-1:0] f_pts, f_dts, f_dur;
   assign f_type   = req_tuser;
   assign f_tag    = req_tdata[31:0];
   assign f_ctag   = req_tdata[63:32];
   assign f_pts_ok = req_tdata[64];
   assign f_pts    = req_tdata[112:65];
   assign f_dts    = req_tdata[160:113];
   assign f_key    = req_tdata[161];
   assign f_dur_ok = req_tdata[162];
   assign f_dur    = req_tdata[210:163];

   state_type              state_ff, state_in;
   logic [31:0]            dflt_ff, dflt_in;
   logic                   have_cfg_ff, have_cfg_in, have_key_ff, have_key_in;
   logic                   have_init_ff, have_init_in, flush_ff, flush_in;
   logic signed [TS_W-1:0] prev_dur_ff, prev_dur_in, lowest_ff, lowest_in;
   logic signed [TS_W-1:0] first_dts_ff, first_dts_in;
   logic [31:0]            emit_idx_ff, emit_idx_in;
   logic [DR_W-1:0]        drop_ff, drop_in, k_ff, k_in;
   logic [PA_W-1:0]        head_ff, head_in, tail_ff, tail_in, idx_ff, idx_in;
   logic [PC_W-1:0]        pcount_ff, pcount_in, left_ff, left_in;
   logic signed [TS_W-1:0] hist_ff [HISTORY];
   logic signed [TS_W-1:0] hist_in [HISTORY];
   logic [HC_W-1:0]        hcount_ff, hcount_in, hidx_ff, hidx_in;
   logic [31:0]            cq_tag_ff [CONFIG_DEPTH];
   logic [31:0]            cq_tag_in [CONFIG_DEPTH];
   logic [31:0]            cq_pos_ff [CONFIG_DEPTH];
   logic [31:0]            cq_pos_in [CONFIG_DEPTH];
   logic [CQ_W-1:0]        cq_count_ff, cq_count_in;
   vftf_pkg::pend_type     fr_ff, fr_in, cur_ff, cur_in;
   logic signed [DIFF_W-1:0] pd_ff, pd_in, dd_ff, dd_in, p_ff, p_in, d_ff, d_in;
   logic signed [DIFF_W-1:0] dvd_ff, dvd_in;
   logic                   div_go_ff, div_go_in, found_ff, found_in;
   logic signed [TS_W-1:0] best_ff, best_in;
   logic [RC_W-1:0]        rc_ff, rc_in;
   logic [1:0]             err_ff, err_in;

   logic                   div_done;
   logic signed [DIFF_W-1:0] div_q;
   logic                   wr_en, rd_en;
   logic [PA_W-1:0]        rd_addr;
   vftf_pkg::pend_type     wr_rec, rd_rec;
   logic [PW-1:0]          rd_raw;
   logic                   put_valid, stage_ready, put_ok, finish, finish_done;
   vftf_pkg::rsp_type      put_rec;
   logic signed [TS_W-1:0] low_new, cand, dur_fin;
   logic                   ann, under_cap;

   function automatic logic [PA_W-1:0] nxt(input logic [PA_W-1:0] a);
      return (a == PA_W'(PEND - 1)) ? '0 : a + 1'b1;
   endfunction

   assign rd_rec    = rd_raw;
   assign under_cap = rc_ff < RC_W'(vftf_pkg::MAX_RESULTS);
   assign put_ok    = !under_cap || stage_ready;
   assign ann       = (cq_count_ff != '0) && (cq_pos_ff[0] == emit_idx_ff);
   assign low_new   = !have_init_ff ? f_pts : ((f_pts < lowest_ff) ? f_pts : lowest_ff);
   assign cand      = hist_ff[hidx_ff[HI_W-1:0]];
   assign dur_fin   = cur_ff.dur_ok ? cur_ff.dur :
                      found_ff ? vftf_pkg::sat_ts({best_ff[TS_W-1], best_ff} -
                                                  {cur_ff.pts[TS_W-1], cur_ff.pts}) :
                      prev_dur_ff;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      dflt_in      = dflt_ff;
      have_cfg_in  = have_cfg_ff;
      have_key_in  = have_key_ff;
      have_init_in = have_init_ff;
      flush_in     = flush_ff;
      prev_dur_in  = prev_dur_ff;
      lowest_in    = lowest_ff;
      first_dts_in = first_dts_ff;
      emit_idx_in  = emit_idx_ff;
      drop_in      = drop_ff;
      k_in         = k_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      idx_in       = idx_ff;
      pcount_in    = pcount_ff;
      left_in      = left_ff;
      hist_in      = hist_ff;
      hcount_in    = hcount_ff;
      hidx_in      = hidx_ff;
      cq_tag_in    = cq_tag_ff;
      cq_pos_in    = cq_pos_ff;
      cq_count_in  = cq_count_ff;
      fr_in        = fr_ff;
      cur_in       = cur_ff;
      pd_in        = pd_ff;
      dd_in        = dd_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      dvd_in       = dvd_ff;
      div_go_in    = 1'b0;
      found_in     = found_ff;
      best_in      = best_ff;
      rc_in        = rc_ff;
      err_in       = err_ff;
      wr_en        = 1'b0;
      wr_rec       = fr_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      put_valid    = 1'b0;
      put_rec      = '0;
      finish       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               flush_in = 1'b0;
               case (f_type)
                  vftf_pkg::REQ_FRAME: begin
                     if (!f_pts_ok) begin
                        if (have_key_ff) begin
                           err_in   = vftf_pkg::KIND_NO_TS;
                           state_in = ST_PUT_ERR;
                        end else if (have_init_ff && drop_ff < DR_W'(MAX_DISCARD)) begin
                           drop_in = drop_ff + 1'b1;
                        end
                     end else begin
                        have_init_in = 1'b1;
                        lowest_in    = low_new;
                        if (!have_init_ff) first_dts_in = f_dts;
                        if (!have_cfg_ff || (!have_key_ff && !f_key)) begin
                           if (drop_ff < DR_W'(MAX_DISCARD)) drop_in = drop_ff + 1'b1;
                        end else begin
                           have_key_in = 1'b1;
                           fr_in = '{tag: f_tag, pts: f_pts, dts: f_dts, dur: f_dur,
                                     dur_ok: f_dur_ok, key: f_key};
                           dvd_in = {f_pts[TS_W-1], f_pts} - {low_new[TS_W-1], low_new};
                           if (drop_ff != '0) begin
                              div_go_in = 1'b1;
                              state_in  = ST_DIV_P;
                           end else begin
                              state_in = ST_PUSH_F;
                           end
                        end
                     end
                  end
                  vftf_pkg::REQ_CONFIG: begin
                     if (cq_count_ff >= CQ_W'(CONFIG_DEPTH)) begin
                        err_in   = vftf_pkg::KIND_CFG_FULL;
                        state_in = ST_PUT_ERR;
                     end else begin
                        cq_tag_in[cq_count_ff[CI_W-1:0]] = f_ctag;
                        cq_pos_in[cq_count_ff[CI_W-1:0]] = emit_idx_ff + 32'(pcount_ff);
                        cq_count_in = cq_count_ff + 1'b1;
                        have_cfg_in = 1'b1;
                        state_in    = ST_CHECK;
                     end
                  end
                  vftf_pkg::REQ_FLUSH: begin
                     flush_in = 1'b1;
                     state_in = ST_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         ST_PUT_ERR: begin
            put_valid    = 1'b1;
            put_rec.kind = err_ff;
            if (put_ok) state_in = ST_FINISH;
         end
         ST_DIV_P: begin
            if (div_done) begin
               pd_in     = div_q;
               dvd_in    = {fr_ff.dts[TS_W-1], fr_ff.dts} -
                           {first_dts_ff[TS_W-1], first_dts_ff};
               div_go_in = 1'b1;
               state_in  = ST_DIV_D;
            end
         end
         ST_DIV_D: begin
            if (div_done) begin
               dd_in    = div_q;
               p_in     = {lowest_ff[TS_W-1], lowest_ff};
               d_in     = {first_dts_ff[TS_W-1], first_dts_ff};
               k_in     = '0;
               state_in = ST_PUSH_I;
            end
         end
         ST_PUSH_I: begin
            wr_en     = 1'b1;
            wr_rec    = '{tag: fr_ff.tag, pts: p_ff[TS_W-1:0], dts: d_ff[TS_W-1:0],
                          dur: vftf_pkg::sat_ts(pd_ff), dur_ok: 1'b1, key: fr_ff.key};
            tail_in   = nxt(tail_ff);
            pcount_in = pcount_ff + 1'b1;
            p_in      = p_ff + pd_ff;
            d_in      = d_ff + dd_ff;
            k_in      = k_ff + 1'b1;
            if (k_ff == drop_ff - 1'b1) begin
               drop_in  = '0;
               state_in = ST_PUSH_F;
            end
         end
         ST_PUSH_F: begin
            wr_en     = 1'b1;
            wr_rec    = fr_ff;
            tail_in   = nxt(tail_ff);
            pcount_in = pcount_ff + 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (pcount_ff == '0 || (!flush_ff && pcount_ff <= PC_W'(HISTORY))) begin
               state_in = ST_FINISH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            put_valid       = ann;
            put_rec.kind    = vftf_pkg::KIND_ANNOUNCE;
            put_rec.cfg_tag = cq_tag_ff[0];
            if (!ann || put_ok) begin
               cur_in = rd_rec;
               if (ann) begin
                  for (int i = 0; i < CONFIG_DEPTH - 1; i++) begin
                     cq_tag_in[i] = cq_tag_ff[i+1];
                     cq_pos_in[i] = cq_pos_ff[i+1];
                  end
                  cq_count_in = cq_count_ff - 1'b1;
               end
               head_in     = nxt(head_ff);
               idx_in      = nxt(head_ff);
               pcount_in   = pcount_ff - 1'b1;
               left_in     = pcount_ff - 1'b1;
               emit_idx_in = emit_idx_ff + 1'b1;
               found_in    = 1'b0;
               hidx_in     = '0;
               if (rd_rec.dur_ok) state_in = ST_EMIT;
               else if (pcount_ff > PC_W'(1)) state_in = ST_SCAN_RD;
               else state_in = ST_HIST;
            end
         end
         ST_SCAN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (rd_rec.pts >= cur_ff.pts && (!found_ff || rd_rec.pts < best_ff)) begin
               best_in  = rd_rec.pts;
               found_in = 1'b1;
            end
            idx_in  = nxt(idx_ff);
            left_in = left_ff - 1'b1;
            state_in = (left_ff == PC_W'(1)) ? ST_HIST : ST_SCAN_RD;
         end
         ST_HIST: begin
            if (hidx_ff < hcount_ff) begin
               if (cand >= cur_ff.pts && (!found_ff || cand < best_ff)) begin
                  best_in  = cand;
                  found_in = 1'b1;
               end
               hidx_in = hidx_ff + 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            put_valid         = 1'b1;
            put_rec.kind      = vftf_pkg::KIND_FRAME;
            put_rec.frame_tag = cur_ff.tag;
            put_rec.pts       = cur_ff.pts;
            put_rec.dts       = cur_ff.dts;
            put_rec.dur       = dur_fin;
            put_rec.key       = cur_ff.key;
            if (put_ok) begin
               if (hcount_ff >= HC_W'(HISTORY)) begin
                  for (int i = 0; i < HISTORY - 1; i++) hist_in[i] = hist_ff[i+1];
                  hist_in[HISTORY-1] = cur_ff.pts;
               end else begin
                  hist_in[hcount_ff[HI_W-1:0]] = cur_ff.pts;
                  hcount_in = hcount_ff + 1'b1;
               end
               prev_dur_in = dur_fin;
               state_in    = ST_CHECK;
            end
         end
         ST_FINISH: begin
            finish = 1'b1;
            if (finish_done) begin
               rc_in    = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (put_valid && put_ok && under_cap) rc_in = rc_ff + 1'b1;

      if (csr_wr_en) begin
         dflt_in = csr_wr_data;
         if (!have_key_ff) prev_dur_in = TS_W'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dflt_ff      <= vftf_pkg::DEFAULT_DURATION;
         have_cfg_ff  <= 1'b0;
         have_key_ff  <= 1'b0;
         have_init_ff <= 1'b0;
         flush_ff     <= 1'b0;
         prev_dur_ff  <= TS_W'(vftf_pkg::DEFAULT_DURATION);
         lowest_ff    <= '0;
         first_dts_ff <= '0;
         emit_idx_ff  <= '0;
         drop_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         pcount_ff    <= '0;
         hcount_ff    <= '0;
         cq_count_ff  <= '0;
         div_go_ff    <= 1'b0;
         rc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         dflt_ff      <= dflt_in;
         have_cfg_ff  <= have_cfg_in;
         have_key_ff  <= have_key_in;
         have_init_ff <= have_init_in;
         flush_ff     <= flush_in;
         prev_dur_ff  <= prev_dur_in;
         lowest_ff    <= lowest_in;
         first_dts_ff <= first_dts_in;
         emit_idx_ff  <= emit_idx_in;
         drop_ff      <= drop_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         pcount_ff    <= pcount_in;
         hcount_ff    <= hcount_in;
         cq_count_ff  <= cq_count_in;
         div_go_ff    <= div_go_in;
         rc_ff        <= rc_in;
      end
      k_ff      <= k_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      hist_ff   <= hist_in;
      hidx_ff   <= hidx_in;
      cq_tag_ff <= cq_tag_in;
      cq_pos_ff <= cq_pos_in;
      fr_ff     <= fr_in;
      cur_ff    <= cur_in;
      pd_ff     <= pd_in;
      dd_ff     <= dd_in;
      p_ff      <= p_in;
      d_ff      <= d_in;
      dvd_ff    <= dvd_in;
      found_ff  <= found_in;
      best_ff   <= best_in;
      err_ff    <= err_in;
   end

   vftf_div #(
      .DVD_W (DIFF_W),
      .DVR_W (DR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (dvd_ff),
      .divisor  (drop_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   vftf_pend_mem #(
      .DEPTH (PEND),
      .WIDTH (PW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   vftf_rsp_stage u_stage (
      .clock       (clock),
      .reset       (reset),
      .put_valid   (put_valid && under_cap),
      .put_rec     (put_rec),
      .put_ready   (stage_ready),
      .finish      (finish),
      .finish_done (finish_done),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );
endmodule
`default_nettype wire

// ----- sv/vftf_checker.sv -----
// port-level checks for the video frame timestamp fixer, bound to the top level
// depends on vftf_pkg and video_frame_timestamp_fixer_top
`default_nettype none
module vftf_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [1:0]                         rsp_tuser,
   input wire                               rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result item right after reset");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == vftf_pkg::KIND_NO_TS ||
                     rsp_tuser == vftf_pkg::KIND_CFG_FULL) |-> rsp_tlast)
      else $error("error item not last");

   a_ann_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == vftf_pkg::KIND_ANNOUNCE |-> !rsp_tlast)
      else $error("announce item without its frame");
endmodule

bind video_frame_timestamp_fixer_top vftf_checker u_vftf_checker (.*);
`default_nettype wire
